// ===== rtl/core/cave_pkg.sv =====
package cave_pkg;

  localparam int ROW_W     = 64;  // cells per row
  localparam int WIDTH_W   = 7;   // active width register
  localparam int CNT_W     = 4;   // neighbour count, 0..8
  localparam int STAY_MIN  = 4;
  localparam int BIRTH_MIN = 5;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  localparam logic [WIDTH_W-1:0] WIDTH_RST = WIDTH_W'(ROW_W);

  // one row update: the three rows around the output row
  typedef struct packed {
    logic [ROW_W-1:0] up;
    logic [ROW_W-1:0] mid;
    logic [ROW_W-1:0] dn;
    logic             frame_end;
  } job_t;

endpackage

// ===== rtl/core/cave_automaton_row_step.sv =====
// Row k's result is formed once row k+1 arrives; the job is queued when that row is
// accepted and then moves into the output register, whose valid bit drives out_valid.
// Throughput: one row per cycle while the queue has space; a chunk's bottom job stalls input.
// The back end's single row evaluator sets the rate: one job per cycle if out_ready allows.
// Reset (synchronous, rst_n low): queue and output empty, row history cleared,
// active width 64, settled tracking restarted.
module cave_automaton_row_step import cave_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [WIDTH_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ROW_W-1:0]   in_row_cells,
  input  logic               in_last_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ROW_W-1:0]   out_new_row,
  output logic               out_frame_end,
  output logic               out_settled
);

  logic q_space, q_push, q_pop, q_head_valid;
  job_t q_job, q_head_job;

  cave_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_row_cells (in_row_cells),
    .in_last_row  (in_last_row),
    .q_space      (q_space),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  cave_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .space      (q_space),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  cave_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .head_valid    (q_head_valid),
    .head_job      (q_head_job),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_new_row   (out_new_row),
    .out_frame_end (out_frame_end),
    .out_settled   (out_settled)
  );

endmodule

// ===== rtl/core/cave_front.sv =====
module cave_front import cave_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ROW_W-1:0] in_row_cells,
  input  logic             in_last_row,
  input  logic             q_space,
  output logic             q_push,
  output job_t             q_job
);

  logic [ROW_W-1:0] above_r, above_nxt;
  logic [ROW_W-1:0] mid_r, mid_nxt;
  logic             primed_r, primed_nxt;  // at least one row held
  logic             tail_r, tail_nxt;      // bottom-row job still to issue
  logic             accept;

  assign in_ready = !tail_r && q_space;
  assign accept   = in_valid && in_ready;

  always_comb begin
    q_push     = 1'b0;
    q_job      = '0;
    above_nxt  = above_r;
    mid_nxt    = mid_r;
    primed_nxt = primed_r;
    tail_nxt   = tail_r;
    if (tail_r) begin
      q_job.up        = above_r;
      q_job.mid       = mid_r;
      q_job.dn        = '0;
      q_job.frame_end = 1'b1;
      if (q_space) begin
        q_push     = 1'b1;
        above_nxt  = '0;
        mid_nxt    = '0;
        primed_nxt = 1'b0;
        tail_nxt   = 1'b0;
      end
    end else if (accept) begin
      if (primed_r) begin
        q_push    = 1'b1;
        q_job.up  = above_r;
        q_job.mid = mid_r;
        q_job.dn  = in_row_cells;
        above_nxt = mid_r;
        mid_nxt   = in_row_cells;
        if (in_last_row) begin
          tail_nxt = 1'b1;
        end
      end else if (in_last_row) begin
        // single-row chunk: rows above and below are empty
        q_push          = 1'b1;
        q_job.up        = '0;
        q_job.mid       = in_row_cells;
        q_job.frame_end = 1'b1;
        above_nxt       = '0;
        mid_nxt         = '0;
      end else begin
        above_nxt  = '0;
        mid_nxt    = in_row_cells;
        primed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r  <= '0;
      mid_r    <= '0;
      primed_r <= 1'b0;
      tail_r   <= 1'b0;
    end else begin
      above_r  <= above_nxt;
      mid_r    <= mid_nxt;
      primed_r <= primed_nxt;
      tail_r   <= tail_nxt;
    end
  end

endmodule

// ===== rtl/core/cave_queue.sv =====
module cave_queue import cave_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic space,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              slot_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign space      = (count_r != Q_CW'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && space;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/cave_back.sv =====
module cave_back import cave_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [WIDTH_W-1:0] cfg_wr_data,
  input  logic               head_valid,
  input  job_t               head_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ROW_W-1:0]   out_new_row,
  output logic               out_frame_end,
  output logic               out_settled
);

  logic [WIDTH_W-1:0] width_r;
  logic [ROW_W-1:0]   mask;
  logic [ROW_W-1:0]   result;
  logic               changed;
  logic               nochg_r, nochg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]   row_r;
  logic               fe_r;
  logic               settled_r;

  // widths above the row length select every column
  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      mask[i] = (width_r > WIDTH_W'(i));
    end
  end

  always_comb begin
    logic [ROW_W+1:0] u, m, d;
    logic [CNT_W-1:0] cnt;
    u = {1'b0, head_job.up  & mask, 1'b0};
    m = {1'b0, head_job.mid & mask, 1'b0};
    d = {1'b0, head_job.dn  & mask, 1'b0};
    for (int x = 0; x < ROW_W; x++) begin
      cnt = CNT_W'(u[x]) + CNT_W'(u[x+1]) + CNT_W'(u[x+2])
          + CNT_W'(m[x]) + CNT_W'(m[x+2])
          + CNT_W'(d[x]) + CNT_W'(d[x+1]) + CNT_W'(d[x+2]);
      result[x] = mask[x] && (m[x+1] ? (cnt >= CNT_W'(STAY_MIN))
                                      : (cnt >= CNT_W'(BIRTH_MIN)));
    end
  end

  assign changed = (result != (head_job.mid & mask));
  assign pop     = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    nochg_nxt     = nochg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      out_valid_nxt = 1'b1;
      nochg_nxt     = head_job.frame_end ? 1'b1 : (nochg_r && !changed);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row_r     <= result;
      fe_r      <= head_job.frame_end;
      settled_r <= head_job.frame_end && nochg_r && !changed;
    end
    if (!rst_n) begin
      width_r     <= WIDTH_RST;
      nochg_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        width_r <= cfg_wr_data;
      end
      nochg_r     <= nochg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_row   = row_r;
  assign out_frame_end = fe_r;
  assign out_settled   = settled_r;

endmodule
